// File: hw/rtl/uvcpfa_pkg.sv
// Shared types and constants for the UVC payload frame assembler.
// No dependencies; imported by uvcpfa_core and the top level.
`timescale 1ns / 1ps
`default_nettype none

package uvcpfa_pkg;

    // Header layout
    localparam logic [7:0] HDR_LEN      = 8'd12;
    localparam int         FLAG_ERR_BIT = 6;
    localparam int         FLAG_PTS_BIT = 2;
    localparam int         FLAG_EOF_BIT = 1;
    localparam int         FLAG_FID_BIT = 0;
    localparam int         PTS_FIRST    = 2;
    localparam int         PTS_BYTES    = 4;

    // Field widths
    localparam int IMAGE_BYTES_W = 23;
    localparam int OFFSET_W      = 22;

    // Configuration register map
    localparam int                       APB_ADDR_W      = 3;
    localparam logic                     REG_IMAGE_BYTES = 1'b0;
    localparam logic [IMAGE_BYTES_W-1:0] IMAGE_BYTES_RST = 23'd307200;

    // Payload / frame classification
    typedef enum logic [1:0] {
        KIND_DISCARD = 2'd0,
        KIND_FIRST   = 2'd1,
        KIND_INTER   = 2'd2,
        KIND_LAST    = 2'd3
    } t_kind;

    // One result per stream byte
    typedef struct packed {
        logic                write_valid;
        logic [OFFSET_W-1:0] write_offset;
        logic [7:0]          write_data;
        logic                payload_end;
        logic                payload_dropped;
        logic                frame_done;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/uvcpfa_core.sv
// Per-byte header parse, payload classification and frame length tracking.
// Holds all assembler state; depends on uvcpfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uvcpfa_core #(
    parameter int PAYLOAD_BYTES   = 2048,
    parameter int MAX_FRAME_BYTES = 4194304
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_fire,
    input  wire logic [7:0]                          i_byte,
    input  wire logic                                i_last,
    input  wire logic [uvcpfa_pkg::IMAGE_BYTES_W-1:0] i_image_bytes,
    output uvcpfa_pkg::t_result                      o_result
);
    import uvcpfa_pkg::*;

    localparam int PW = $clog2(PAYLOAD_BYTES);
    localparam int FW = IMAGE_BYTES_W;
    localparam logic [PW-1:0] LAST_POS = PW'(PAYLOAD_BYTES - 1);
    localparam logic [PW-1:0] CLS_POS  = PW'(HDR_LEN - 8'd1);
    localparam logic [PW-1:0] DATA_POS = PW'(HDR_LEN);
    localparam logic [FW+1:0] MAX_W    = (FW+2)'(MAX_FRAME_BYTES);

    // Assembler state
    logic [31:0]   r_prev_pts, n_prev_pts;
    logic          r_prev_fid, n_prev_fid;
    t_kind         r_prev_kind, n_prev_kind;
    logic [FW-1:0] r_frame_len, n_frame_len;
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_count, n_count;
    logic [7:0]    r_flags, n_flags;
    logic [31:0]   r_pts, n_pts;
    logic          r_hl_ok, n_hl_ok;
    t_kind         r_action, n_action;

    logic [FW-1:0] w_eff;
    logic [FW+1:0] w_eff_wide;

    // Saturate configured frame size
    assign w_eff_wide = ({2'b00, i_image_bytes} < MAX_W) ? {2'b00, i_image_bytes} : MAX_W;
    assign w_eff      = w_eff_wide[FW-1:0];

    // Step logic for one byte
    always_comb begin
        t_kind         cls;
        t_kind         act_cur;
        t_kind         act_end;
        logic          pend;
        logic          live;
        logic          wvalid;
        logic [FW:0]   base;
        logic [FW:0]   off;
        logic [PW-1:0] d;
        logic [FW:0]   sum;
        logic          dropped;
        logic          done;

        n_prev_pts  = r_prev_pts;
        n_prev_fid  = r_prev_fid;
        n_prev_kind = r_prev_kind;
        n_frame_len = r_frame_len;
        n_pos       = r_pos;
        n_count     = r_count;
        n_flags     = r_flags;
        n_pts       = r_pts;
        n_hl_ok     = r_hl_ok;
        n_action    = r_action;

        pend = i_last || (r_pos >= LAST_POS);

        // Capture header fields
        if (r_pos == '0) begin
            n_hl_ok = (i_byte == HDR_LEN);
        end
        if (r_pos == PW'(1)) begin
            n_flags = i_byte;
        end
        for (int k = 0; k < PTS_BYTES; k++) begin
            if (r_pos == PW'(PTS_FIRST + k)) begin
                n_pts[8*k +: 8] = i_byte;
            end
        end

        // Classify once the header is complete
        if (!r_hl_ok || r_flags[FLAG_ERR_BIT] || !r_flags[FLAG_PTS_BIT]) begin
            cls = KIND_DISCARD;
        end else if (r_pts != r_prev_pts || r_flags[FLAG_FID_BIT] != r_prev_fid) begin
            cls = KIND_FIRST;
        end else if (r_flags[FLAG_EOF_BIT]) begin
            cls = KIND_LAST;
        end else begin
            cls = KIND_INTER;
        end
        act_cur = (r_pos == CLS_POS) ? cls : r_action;
        n_action = act_cur;

        // Data byte write
        base   = (r_action == KIND_FIRST) ? '0 : {1'b0, r_frame_len};
        off    = base + (FW+1)'(r_count);
        live   = (r_action == KIND_FIRST) ||
                 ((r_action == KIND_INTER || r_action == KIND_LAST) &&
                  (r_prev_kind == KIND_FIRST || r_prev_kind == KIND_INTER));
        wvalid = (r_pos >= DATA_POS) && live && (off < {1'b0, w_eff});
        d      = (r_pos >= DATA_POS) ? r_count + PW'(1) : r_count;
        n_count = d;

        // Payload end decision
        act_end = (r_pos >= CLS_POS) ? act_cur : KIND_DISCARD;
        sum     = {1'b0, r_frame_len} + (FW+1)'(d);
        dropped = 1'b1;
        done    = 1'b0;
        if (pend) begin
            unique case (act_end)
                KIND_FIRST: begin
                    n_prev_pts = r_pts;
                    n_prev_fid = r_flags[FLAG_FID_BIT];
                    if (d != '0 && (FW+1)'(d) > {1'b0, w_eff}) begin
                        n_prev_kind = KIND_DISCARD;
                        n_frame_len = '0;
                    end else begin
                        n_prev_kind = KIND_FIRST;
                        n_frame_len = FW'(d);
                        dropped     = 1'b0;
                    end
                end
                KIND_LAST: begin
                    n_prev_pts = '0;
                    if (sum != {1'b0, w_eff}) begin
                        if (r_prev_kind == KIND_FIRST || r_prev_kind == KIND_INTER) begin
                            n_prev_kind = KIND_DISCARD;
                        end
                    end else if (r_prev_kind == KIND_DISCARD) begin
                        n_prev_kind = KIND_LAST;
                        n_frame_len = '0;
                    end else if (r_prev_kind != KIND_LAST) begin
                        n_prev_kind = KIND_LAST;
                        n_frame_len = '0;
                        dropped     = 1'b0;
                        done        = 1'b1;
                    end
                end
                KIND_INTER: begin
                    if (r_prev_kind == KIND_FIRST || r_prev_kind == KIND_INTER) begin
                        if (d != '0 && sum > {1'b0, w_eff}) begin
                            n_prev_kind = KIND_DISCARD;
                            n_frame_len = '0;
                        end else begin
                            n_prev_kind = KIND_INTER;
                            n_frame_len = sum[FW-1:0];
                            dropped     = 1'b0;
                        end
                    end
                end
                default: begin
                    if (r_prev_kind == KIND_FIRST || r_prev_kind == KIND_INTER) begin
                        n_prev_kind = KIND_DISCARD;
                    end
                end
            endcase
            // Clear per-payload state
            n_pos    = '0;
            n_count  = '0;
            n_action = KIND_DISCARD;
            n_hl_ok  = 1'b0;
            n_flags  = '0;
            n_pts    = '0;
        end else begin
            n_pos = r_pos + PW'(1);
        end

        o_result.write_valid     = wvalid;
        o_result.write_offset    = wvalid ? off[OFFSET_W-1:0] : '0;
        o_result.write_data      = wvalid ? i_byte : '0;
        o_result.payload_end     = pend;
        o_result.payload_dropped = pend && dropped;
        o_result.frame_done      = done;
    end

    // Advance state on each processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pts  <= '0;
            r_prev_fid  <= 1'b0;
            r_prev_kind <= KIND_LAST;
            r_frame_len <= '0;
            r_pos       <= '0;
            r_count     <= '0;
            r_flags     <= '0;
            r_pts       <= '0;
            r_hl_ok     <= 1'b0;
            r_action    <= KIND_DISCARD;
        end else if (i_fire) begin
            r_prev_pts  <= n_prev_pts;
            r_prev_fid  <= n_prev_fid;
            r_prev_kind <= n_prev_kind;
            r_frame_len <= n_frame_len;
            r_pos       <= n_pos;
            r_count     <= n_count;
            r_flags     <= n_flags;
            r_pts       <= n_pts;
            r_hl_ok     <= n_hl_ok;
            r_action    <= n_action;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/uvc_payload_frame_assembler_top.sv
// Input transfer to result valid passes the input register, then the result register.
// Throughput: one byte per cycle without output stalls; one add/compare pass per byte in uvcpfa_core.
// Input is taken while a result waits, as long as the input register is free or drains.
// Reset (synchronous, active low): image size = 307200, previous kind = last, valids and state zero.
// Top level: handshake registers, APB image size register, core instance.
// Depends on uvcpfa_pkg and uvcpfa_core.
`timescale 1ns / 1ps
`default_nettype none

module uvc_payload_frame_assembler_top #(
    parameter int PAYLOAD_BYTES   = 2048,
    parameter int MAX_FRAME_BYTES = 4194304
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Stream input
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [7:0]                        i_byte_in,
    input  wire logic                              i_transfer_last,
    // Result output
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_write_valid,
    output logic [uvcpfa_pkg::OFFSET_W-1:0]        o_write_offset,
    output logic [7:0]                             o_write_data,
    output logic                                   o_payload_end,
    output logic                                   o_payload_dropped,
    output logic                                   o_frame_done,
    // Configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [uvcpfa_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import uvcpfa_pkg::*;

    logic                     r_in_valid;
    logic [7:0]               r_in_byte;
    logic                     r_in_last;
    logic                     r_out_valid;
    t_result                  r_out;
    logic [IMAGE_BYTES_W-1:0] r_image_bytes;
    logic                     w_adv;
    logic                     w_fire;
    t_result                  w_result;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IMAGE_BYTES) ? {{(32-IMAGE_BYTES_W){1'b0}}, r_image_bytes}
                                                  : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_bytes <= IMAGE_BYTES_RST;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_IMAGE_BYTES) begin
            r_image_bytes <= pwdata[IMAGE_BYTES_W-1:0];
        end
    end

    // Handshake: process when the result register is free or drains
    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && w_adv;
    assign o_in_ready = !r_in_valid || w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_byte_in;
            r_in_last <= i_transfer_last;
        end
    end

    uvcpfa_core #(
        .PAYLOAD_BYTES  (PAYLOAD_BYTES),
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_byte       (r_in_byte),
        .i_last       (r_in_last),
        .i_image_bytes(r_image_bytes),
        .o_result     (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_write_valid     = r_out.write_valid;
    assign o_write_offset    = r_out.write_offset;
    assign o_write_data      = r_out.write_data;
    assign o_payload_end     = r_out.payload_end;
    assign o_payload_dropped = r_out.payload_dropped;
    assign o_frame_done      = r_out.frame_done;

endmodule

`default_nettype wire

// File: verif/uvcpfa_frame_check_pkg.sv
// Scoreboard for the UVC payload frame assembler: per-byte prediction of the
// frame-buffer write, payload end, drop and frame-done outputs.
// Depends on uvcpfa_pkg for the header layout, the kind enum and the result type.
`timescale 1ns / 1ps

package uvcpfa_frame_check_pkg;

    import uvcpfa_pkg::*;

    localparam int unsigned PAYLOAD_BYTES   = 2048;
    localparam int unsigned MAX_FRAME_BYTES = 4194304;
    localparam int unsigned MAX_REPORTS     = 10;

    localparam logic [7:0] ERR_MASK = 8'(1 << FLAG_ERR_BIT);
    localparam logic [7:0] PTS_MASK = 8'(1 << FLAG_PTS_BIT);
    localparam logic [7:0] EOF_MASK = 8'(1 << FLAG_EOF_BIT);
    localparam logic [7:0] FID_MASK = 8'(1 << FLAG_FID_BIT);

    class frame_write_scoreboard;
        // configuration and frame state
        logic [IMAGE_BYTES_W-1:0] image_bytes;
        logic [31:0]              prev_pts;
        logic                     prev_fid;
        t_kind                    prev_kind;
        logic [IMAGE_BYTES_W-1:0] frame_len;
        // payload parsing state
        logic [11:0]              payload_pos;
        logic [11:0]              data_count;
        logic [7:0]               hdr_flags;
        logic [31:0]              pts_acc;
        logic                     hdr_len_ok;
        t_kind                    action;

        t_result                  expected_writes[$];
        int unsigned              errors;
        int unsigned              checked;

        function new();
            image_bytes = IMAGE_BYTES_RST;
            prev_pts    = '0;
            prev_fid    = 1'b0;
            prev_kind   = KIND_LAST;
            frame_len   = '0;
            payload_pos = '0;
            data_count  = '0;
            hdr_flags   = '0;
            pts_acc     = '0;
            hdr_len_ok  = 1'b0;
            action      = KIND_DISCARD;
            errors      = 0;
            checked     = 0;
        endfunction

        function int unsigned pending();
            return expected_writes.size();
        endfunction

        // Saturate the programmed size at the buffer capacity
        function logic [31:0] usable_size();
            return (image_bytes < MAX_FRAME_BYTES) ? 32'(image_bytes) : MAX_FRAME_BYTES;
        endfunction

        function t_kind classify_header();
            if (!hdr_len_ok || hdr_flags[FLAG_ERR_BIT] || !hdr_flags[FLAG_PTS_BIT])
                return KIND_DISCARD;
            if (pts_acc != prev_pts || hdr_flags[FLAG_FID_BIT] != prev_fid)
                return KIND_FIRST;
            if (hdr_flags[FLAG_EOF_BIT])
                return KIND_LAST;
            return KIND_INTER;
        endfunction

        function void abandon_frame();
            if (prev_kind == KIND_FIRST || prev_kind == KIND_INTER)
                prev_kind = KIND_DISCARD;
        endfunction

        // Grow the frame by count bytes; an overflow kills the frame
        function logic append_data(t_kind kind, logic [31:0] count);
            if (count != 0) begin
                if (32'(frame_len) + count > usable_size()) begin
                    prev_kind = KIND_DISCARD;
                    frame_len = '0;
                    return 1'b0;
                end
                frame_len = IMAGE_BYTES_W'(32'(frame_len) + count);
            end
            prev_kind = kind;
            return 1'b1;
        endfunction

        // Decide the fate of a payload on its last byte
        function void close_payload(t_kind act, logic [31:0] count,
                                    output logic dropped, output logic done);
            dropped = 1'b1;
            done    = 1'b0;
            case (act)
                KIND_FIRST: begin
                    if (prev_kind == KIND_INTER)
                        prev_kind = KIND_DISCARD;
                    prev_pts  = pts_acc;
                    prev_fid  = hdr_flags[FLAG_FID_BIT];
                    frame_len = '0;
                    dropped   = !append_data(KIND_FIRST, count);
                end
                KIND_LAST: begin
                    prev_pts = '0;
                    if (32'(frame_len) + count != usable_size()) begin
                        abandon_frame();
                    end else if (prev_kind == KIND_DISCARD) begin
                        prev_kind = KIND_LAST;
                        frame_len = '0;
                    end else if (prev_kind != KIND_LAST) begin
                        frame_len = '0;
                        prev_kind = KIND_LAST;
                        dropped   = 1'b0;
                        done      = 1'b1;
                    end
                end
                KIND_INTER: begin
                    if (prev_kind == KIND_FIRST || prev_kind == KIND_INTER)
                        dropped = !append_data(KIND_INTER, count);
                end
                default: abandon_frame();
            endcase
        endfunction

        // Work out the result of one stream byte and advance the state
        function t_result predict_write(logic [7:0] value, logic last);
            t_result     r;
            logic [31:0] pos;
            logic [31:0] offset;
            logic        closing;
            logic        live;
            logic        dropped;
            logic        done;
            t_kind       act;
            r       = '0;
            pos     = 32'(payload_pos);
            closing = last || (pos >= PAYLOAD_BYTES - 1);
            dropped = 1'b0;
            done    = 1'b0;

            // collect the header fields
            if (pos == 0)
                hdr_len_ok = (value == HDR_LEN);
            else if (pos == 1)
                hdr_flags = value;
            else if (pos >= PTS_FIRST && pos < PTS_FIRST + PTS_BYTES)
                pts_acc[8*(pos-PTS_FIRST) +: 8] = value;
            if (pos == HDR_LEN - 1)
                action = classify_header();

            // data byte: write it if the frame is alive and it fits
            if (pos >= HDR_LEN) begin
                offset = ((action == KIND_FIRST) ? 32'd0 : 32'(frame_len)) + 32'(data_count);
                live = (action == KIND_FIRST) ||
                       ((action == KIND_INTER || action == KIND_LAST) &&
                        (prev_kind == KIND_FIRST || prev_kind == KIND_INTER));
                if (live && offset < usable_size()) begin
                    r.write_valid  = 1'b1;
                    r.write_offset = offset[OFFSET_W-1:0];
                    r.write_data   = value;
                end
                data_count = data_count + 12'd1;
            end

            if (closing) begin
                act = (pos >= HDR_LEN - 1) ? action : KIND_DISCARD;
                close_payload(act, 32'(data_count), dropped, done);
                payload_pos = '0;
                data_count  = '0;
                action      = KIND_DISCARD;
                hdr_len_ok  = 1'b0;
                hdr_flags   = '0;
                pts_acc     = '0;
            end else begin
                payload_pos = payload_pos + 12'd1;
            end

            r.payload_end     = closing;
            r.payload_dropped = closing && dropped;
            r.frame_done      = done;
            return r;
        endfunction

        function void note_byte(logic [7:0] value, logic last);
            expected_writes.push_back(predict_write(value, last));
        endfunction

        function void report_error(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%s", msg);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
                report_error($sformatf("result %0d: %s expected %0h, got %0h",
                                       checked, field, want, got));
        endfunction

        // Match one result against the oldest expectation
        function void check_write(t_result got);
            t_result want;
            if (expected_writes.size() == 0) begin
                report_error($sformatf("result %0d arrived with nothing expected", checked));
                checked++;
                return;
            end
            want = expected_writes.pop_front();
            compare_field("write_valid", 32'(want.write_valid), 32'(got.write_valid));
            compare_field("write_offset", 32'(want.write_offset), 32'(got.write_offset));
            compare_field("write_data", 32'(want.write_data), 32'(got.write_data));
            compare_field("payload_end", 32'(want.payload_end), 32'(got.payload_end));
            compare_field("payload_dropped", 32'(want.payload_dropped),
                          32'(got.payload_dropped));
            compare_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
            checked++;
        endfunction
    endclass

endpackage

// File: verif/uvc_payload_frame_assembler_top_test.sv
// Self-checking test of uvc_payload_frame_assembler_top: drives framed and noisy
// byte streams under random back-pressure and checks every per-byte result.
// Depends on uvcpfa_pkg, uvcpfa_frame_check_pkg and the assembler RTL.
`timescale 1ns / 1ps

module uvc_payload_frame_assembler_top_test;

    import uvcpfa_pkg::*;
    import uvcpfa_frame_check_pkg::*;

    localparam logic [APB_ADDR_W-1:0] IMAGE_BYTES_ADDR = APB_ADDR_W'(4 * REG_IMAGE_BYTES);

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_in_valid      = 1'b0;
    logic                  o_in_ready;
    logic [7:0]            i_byte_in       = '0;
    logic                  i_transfer_last = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready     = 1'b0;
    logic                  o_write_valid;
    logic [OFFSET_W-1:0]   o_write_offset;
    logic [7:0]            o_write_data;
    logic                  o_payload_end;
    logic                  o_payload_dropped;
    logic                  o_frame_done;
    logic                  psel            = 1'b0;
    logic                  penable         = 1'b0;
    logic                  pwrite          = 1'b0;
    logic [APB_ADDR_W-1:0] paddr           = '0;
    logic [31:0]           pwdata          = '0;
    logic [31:0]           prdata;
    logic                  pready;

    frame_write_scoreboard    frame_check = new();
    int unsigned              send_idle_pct = 0;
    int unsigned              recv_idle_pct = 0;
    int unsigned              bytes_sent    = 0;
    logic [IMAGE_BYTES_W-1:0] frame_bytes   = IMAGE_BYTES_RST;
    logic                     fid_state     = 1'b0;

    uvc_payload_frame_assembler_top #(
        .PAYLOAD_BYTES  (PAYLOAD_BYTES),
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_byte_in        (i_byte_in),
        .i_transfer_last  (i_transfer_last),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_write_valid    (o_write_valid),
        .o_write_offset   (o_write_offset),
        .o_write_data     (o_write_data),
        .o_payload_end    (o_payload_end),
        .o_payload_dropped(o_payload_dropped),
        .o_frame_done     (o_frame_done),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // 50 MHz clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Stall the result side at random
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Check each result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            frame_check.check_write({o_write_valid, o_write_offset, o_write_data,
                                     o_payload_end, o_payload_dropped, o_frame_done});
    end

    // Hard stop in case the block hangs
    initial begin
        #10_000_000;
        $display("uvc_payload_frame_assembler_top_test: errors");
        $finish;
    end

    // Offer one byte, with a random gap in front, and hold it until transfer
    task automatic send_byte(input logic [7:0] value, input logic last);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid      <= 1'b1;
        i_byte_in       <= value;
        i_transfer_last <= last;
        do @(posedge i_clk); while (!o_in_ready);
        frame_check.note_byte(value, last);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Header bytes first, random filler and data after
    task automatic send_payload(input logic [7:0] hlen, input logic [7:0] flags,
                                input logic [31:0] pts, input int unsigned n_bytes,
                                input logic end_mark);
        logic [7:0] value;
        for (int unsigned i = 0; i < n_bytes; i++) begin
            if (i == 0)
                value = hlen;
            else if (i == 1)
                value = flags;
            else if (i >= PTS_FIRST && i < PTS_FIRST + PTS_BYTES)
                value = pts[8*(i-PTS_FIRST) +: 8];
            else
                value = 8'($urandom_range(0, 255));
            send_byte(value, end_mark && (i == n_bytes - 1));
        end
    endtask

    // One frame split over a few payloads, some of them damaged
    task automatic send_frame();
        logic [31:0] pts;
        logic [7:0]  hlen;
        logic [7:0]  flags;
        int unsigned left;
        int unsigned n_data;
        int unsigned n_bytes;
        int unsigned n_pay;
        // mostly a fresh timestamp; now and then the cleared one, so the
        // payloads continue a frame that has already ended
        if ($urandom_range(0, 9) == 0) begin
            pts = '0;
        end else begin
            pts = $urandom;
            if ($urandom_range(0, 4) != 0)
                fid_state = ~fid_state;
        end
        left  = (frame_bytes > 150) ? $urandom_range(1, 150) : 32'(frame_bytes);
        n_pay = $urandom_range(1, 4);
        for (int unsigned k = 0; k < n_pay; k++) begin
            n_data  = (k == n_pay - 1) ? left : $urandom_range(0, left);
            left    = left - n_data;
            hlen    = HDR_LEN;
            flags   = (8'($urandom_range(0, 255)) & ~(ERR_MASK | EOF_MASK | FID_MASK)) |
                      PTS_MASK | ((k == n_pay - 1) ? EOF_MASK : 8'h00) |
                      (fid_state ? FID_MASK : 8'h00);
            n_bytes = HDR_LEN + n_data;
            case ($urandom_range(0, 29))
                0: hlen = 8'($urandom_range(0, 255));
                1: flags = flags | ERR_MASK;
                2: flags = flags & ~PTS_MASK;
                3: flags = flags ^ EOF_MASK;
                4: flags = 8'($urandom_range(0, 255));
                5: n_bytes = $urandom_range(1, HDR_LEN - 1);
                6: n_bytes = n_bytes + $urandom_range(1, 3);
                default: ;
            endcase
            send_payload(hlen, flags, pts, n_bytes, 1'b1);
        end
    endtask

    // Frames mixed with raw noise until n_items more bytes have gone in
    task automatic run_stream(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned n_noise;
        stop_at = bytes_sent + n_items;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                n_noise = $urandom_range(1, 20);
                for (int unsigned i = 0; i < n_noise; i++)
                    send_byte(8'($urandom_range(0, 255)),
                              (i == n_noise - 1) || ($urandom_range(0, 3) == 0));
            end else begin
                send_frame();
            end
        end
    endtask

    // Drop valid and wait for every outstanding result, then idle as long as extra asks
    task automatic drain_results(input int unsigned extra);
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (frame_check.pending() != 0);
        repeat (extra) @(negedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic write_image_bytes(input logic [IMAGE_BYTES_W-1:0] value);
        drain_results(4);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= IMAGE_BYTES_ADDR;
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        frame_check.image_bytes = value;
        frame_bytes = value;
        @(negedge i_clk);
    endtask

    function automatic logic [IMAGE_BYTES_W-1:0] pick_image_bytes();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return IMAGE_BYTES_W'($urandom_range(65, 600));
            default: return IMAGE_BYTES_W'($urandom_range(1, 64));
        endcase
    endfunction

    initial begin
        // hold reset, then release it
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // slow sender against a mostly stalled receiver
        send_idle_pct = 29;
        recv_idle_pct = 82;
        run_stream(40);

        // directed: runt payload with extreme bytes, then a one-byte frame
        // closed by an EOF payload without data
        write_image_bytes(IMAGE_BYTES_W'(1));
        send_payload(8'h00, 8'hFF, 32'h0, 2, 1'b1);
        send_payload(HDR_LEN, PTS_MASK | EOF_MASK | FID_MASK, 32'hFFFF_FFFF, HDR_LEN + 1, 1'b1);
        send_payload(HDR_LEN, PTS_MASK | EOF_MASK | FID_MASK, 32'hFFFF_FFFF, HDR_LEN, 1'b1);
        fid_state = 1'b1;
        run_stream(150);

        // zero frame size: nothing is ever written
        write_image_bytes('0);
        run_stream(150);
        repeat (2) begin
            write_image_bytes(pick_image_bytes());
            run_stream(150);
        end

        // swap the stall pattern; pause the sender until results catch up
        send_idle_pct = 82;
        recv_idle_pct = 29;
        write_image_bytes(IMAGE_BYTES_W'(MAX_FRAME_BYTES));
        run_stream(150);
        repeat (3) begin
            write_image_bytes(pick_image_bytes());
            run_stream(100);
            drain_results(0);
            run_stream(50);
        end

        // full rate on both sides; saturated size with one full-length payload
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_image_bytes('1);
        fid_state = ~fid_state;
        send_payload(HDR_LEN, PTS_MASK | (fid_state ? FID_MASK : 8'h00), $urandom,
                     PAYLOAD_BYTES, 1'($urandom_range(0, 1)));
        run_stream(100);
        repeat (2) begin
            write_image_bytes(pick_image_bytes());
            run_stream(200);
        end
        write_image_bytes(IMAGE_BYTES_W'(2));
        run_stream(200);

        // let the pipeline empty out
        drain_results(10);
        if (frame_check.errors == 0 && frame_check.pending() == 0)
            $display("uvc_payload_frame_assembler_top_test: clean");
        else
            $display("uvc_payload_frame_assembler_top_test: errors");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/uvcpfa_pkg.sv
hw/rtl/uvcpfa_core.sv
hw/rtl/uvc_payload_frame_assembler_top.sv
verif/uvcpfa_frame_check_pkg.sv
verif/uvc_payload_frame_assembler_top_test.sv
